/* design/lcdns_pkg.sv */
// Package for the character-LCD nibble sequencer.
// Holds request codes, LCD command bytes, the queue job and result types,
// and the fixed power-up strobe table. No dependencies.
`default_nettype none
package lcdns_pkg;

  // Request codes on the input channel
  localparam logic [3:0] CMD_INIT      = 4'd0;
  localparam logic [3:0] CMD_CMD_BYTE  = 4'd1;
  localparam logic [3:0] CMD_DATA_BYTE = 4'd2;
  localparam logic [3:0] CMD_CLEAR     = 4'd3;
  localparam logic [3:0] CMD_HOME      = 4'd4;
  localparam logic [3:0] CMD_CURSOR    = 4'd5;
  localparam logic [3:0] CMD_DISP_ON   = 4'd6;
  localparam logic [3:0] CMD_DISP_OFF  = 4'd7;
  localparam logic [3:0] CMD_GLYPH     = 4'd8;

  // LCD command bytes
  localparam logic [7:0] BYTE_CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] BYTE_RETURN_HOME   = 8'h02;
  localparam logic [7:0] LCD_DISPLAY_CTRL   = 8'h08;
  localparam logic [7:0] LCD_CGRAM_ADDR     = 8'h40;
  localparam logic [7:0] LCD_DDRAM_ADDR     = 8'h80;
  localparam logic [6:0] LCD_ROW1_OFFSET    = 7'h40;

  // Display control bits: display, cursor, blink
  localparam logic [2:0] CTRL_DISPLAY_ON = 3'h4;
  localparam logic [2:0] CTRL_KEEP_MASK  = 3'h3;

  // Waits in microseconds
  localparam logic [15:0] WAIT_BASE      = 16'd50;
  localparam logic [15:0] WAIT_LONG      = 16'd2050;
  localparam logic [15:0] WAIT_POWER_UP  = 16'd50000;
  localparam logic [15:0] WAIT_FIRST_NIB = 16'd5050;
  localparam logic [15:0] WAIT_NIB       = 16'd200;
  localparam logic [15:0] WAIT_BYTE_EXT  = 16'd100;

  // Configuration port
  localparam int         CFG_ADDR_W      = 3;
  localparam int         CFG_DATA_W      = 32;
  localparam logic       REG_IDX_COLUMNS = 1'b0;
  localparam logic       REG_IDX_ROWS    = 1'b1;
  localparam logic [5:0] COLUMNS_RESET   = 6'd16;
  localparam logic [1:0] ROWS_RESET      = 2'd2;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Step index of the final result of a glyph job
  localparam logic [4:0] GLYPH_LAST_STEP = 5'd19;

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_INIT,
    JOB_GLYPH
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        rs;
    logic [7:0]  byte_val;
    logic        long_wait;
    logic [63:0] glyph;
  } job_t;

  typedef struct packed {
    logic        strobe_res;
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        last;
  } result_t;

  // Power-up sequence: delay, nibbles 3,3,3,2, then 0x28,0x08,0x01,0x06,0x0C
  function automatic result_t init_step(input logic [4:0] idx);
    result_t r;
    r = '0;
    case (idx)
      5'd0:  r = '{1'b0, 1'b0, 4'h0, WAIT_POWER_UP, 1'b0};
      5'd1:  r = '{1'b1, 1'b0, 4'h3, WAIT_FIRST_NIB, 1'b0};
      5'd2:  r = '{1'b1, 1'b0, 4'h3, WAIT_NIB, 1'b0};
      5'd3:  r = '{1'b1, 1'b0, 4'h3, WAIT_NIB, 1'b0};
      5'd4:  r = '{1'b1, 1'b0, 4'h2, WAIT_NIB, 1'b0};
      5'd5:  r = '{1'b1, 1'b0, 4'h2, WAIT_BASE, 1'b0};
      5'd6:  r = '{1'b1, 1'b0, 4'h8, WAIT_BYTE_EXT, 1'b0};
      5'd7:  r = '{1'b1, 1'b0, 4'h0, WAIT_BASE, 1'b0};
      5'd8:  r = '{1'b1, 1'b0, 4'h8, WAIT_BYTE_EXT, 1'b0};
      5'd9:  r = '{1'b1, 1'b0, 4'h0, WAIT_BASE, 1'b0};
      5'd10: r = '{1'b1, 1'b0, 4'h1, WAIT_LONG, 1'b0};
      5'd11: r = '{1'b1, 1'b0, 4'h0, WAIT_BASE, 1'b0};
      5'd12: r = '{1'b1, 1'b0, 4'h6, WAIT_BYTE_EXT, 1'b0};
      5'd13: r = '{1'b1, 1'b0, 4'h0, WAIT_BASE, 1'b0};
      5'd14: r = '{1'b1, 1'b0, 4'hC, WAIT_BYTE_EXT, 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/lcdns_in_if.sv */
// Request channel interface: valid/ready handshake plus request fields.
// No dependencies.
`default_nettype none
interface lcdns_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [7:0]  byte_value;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [7:0]  location;
  logic [63:0] glyph;

  modport source (output valid, cmd, byte_value, row, col, location, glyph, input ready);
  modport sink   (input valid, cmd, byte_value, row, col, location, glyph, output ready);
endinterface
`default_nettype wire

/* design/lcdns_out_if.sv */
// Strobe result channel interface: valid/ready handshake plus strobe fields.
// No dependencies.
`default_nettype none
interface lcdns_out_if;
  logic        valid;
  logic        ready;
  logic        strobe_res;
  logic        rs;
  logic [3:0]  nibble;
  logic [15:0] wait_us;
  logic        last;

  modport source (output valid, strobe_res, rs, nibble, wait_us, last, input ready);
  modport sink   (input valid, strobe_res, rs, nibble, wait_us, last, output ready);
endinterface
`default_nettype wire

/* design/lcdns_front.sv */
// Front end: accepts requests, clamps cursor position, tracks display control
// bits, turns known requests into queue jobs. Uses lcdns_pkg, lcdns_in_if.
`default_nettype none
module lcdns_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  lcdns_in_if.sink                in_if,
  input  wire logic [5:0]         columns,
  input  wire logic [1:0]         rows,
  output lcdns_pkg::job_t         push_job,
  output logic                    push_valid,
  input  wire logic               push_ready
);

  logic [2:0] ctrl_r;
  logic [2:0] ctrl_nxt;
  logic       accept;
  logic       known;
  logic [5:0] max_col;
  logic [5:0] col_clamped;
  logic       row_sel;
  logic [6:0] ddram_addr;

  assign in_if.ready = push_ready;
  assign accept      = in_if.valid && push_ready;
  assign push_valid  = in_if.valid && known;

  // Zero-sized settings act as one; only two row offsets exist
  assign max_col     = (columns == 6'd0) ? 6'd0 : columns - 6'd1;
  assign col_clamped = ({2'b00, max_col} < in_if.col) ? max_col : in_if.col[5:0];
  assign row_sel     = (in_if.row != 8'd0) && rows[1];
  assign ddram_addr  = {1'b0, col_clamped} + (row_sel ? lcdns_pkg::LCD_ROW1_OFFSET : 7'd0);

  always_comb begin
    push_job           = '0;
    push_job.kind      = lcdns_pkg::JOB_BYTE;
    push_job.glyph     = in_if.glyph;
    known              = 1'b1;
    ctrl_nxt           = ctrl_r;
    case (in_if.cmd)
      lcdns_pkg::CMD_INIT: begin
        push_job.kind = lcdns_pkg::JOB_INIT;
        ctrl_nxt      = lcdns_pkg::CTRL_DISPLAY_ON;
      end
      lcdns_pkg::CMD_CMD_BYTE: begin
        push_job.byte_val = in_if.byte_value;
      end
      lcdns_pkg::CMD_DATA_BYTE: begin
        push_job.rs       = 1'b1;
        push_job.byte_val = in_if.byte_value;
      end
      lcdns_pkg::CMD_CLEAR: begin
        push_job.byte_val  = lcdns_pkg::BYTE_CLEAR_DISPLAY;
        push_job.long_wait = 1'b1;
      end
      lcdns_pkg::CMD_HOME: begin
        push_job.byte_val  = lcdns_pkg::BYTE_RETURN_HOME;
        push_job.long_wait = 1'b1;
      end
      lcdns_pkg::CMD_CURSOR: begin
        push_job.byte_val = lcdns_pkg::LCD_DDRAM_ADDR | {1'b0, ddram_addr};
      end
      lcdns_pkg::CMD_DISP_ON: begin
        ctrl_nxt          = ctrl_r | lcdns_pkg::CTRL_DISPLAY_ON;
        push_job.byte_val = lcdns_pkg::LCD_DISPLAY_CTRL | {5'b0, ctrl_nxt};
      end
      lcdns_pkg::CMD_DISP_OFF: begin
        ctrl_nxt          = ctrl_r & lcdns_pkg::CTRL_KEEP_MASK;
        push_job.byte_val = lcdns_pkg::LCD_DISPLAY_CTRL | {5'b0, ctrl_nxt};
      end
      lcdns_pkg::CMD_GLYPH: begin
        push_job.kind     = lcdns_pkg::JOB_GLYPH;
        push_job.byte_val = lcdns_pkg::LCD_CGRAM_ADDR | {2'b00, in_if.location[2:0], 3'b000};
      end
      default: begin
        // drop unknown requests
        known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= 3'd0;
    end else if (accept) begin
      ctrl_r <= ctrl_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/lcdns_queue.sv */
// Job queue between front end and strobe sequencer.
// Small circular buffer of lcdns_pkg::job_t entries.
`default_nettype none
module lcdns_queue #(
  parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lcdns_pkg::job_t   push_job,
  input  wire logic              push_valid,
  output logic                   push_ready,
  output lcdns_pkg::job_t        pop_job,
  output logic                   pop_valid,
  input  wire logic              pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcdns_pkg::job_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/lcdns_back.sv */
// Strobe sequencer: walks the head job step by step, emitting one strobe per
// cycle into the output register unless stalled. Uses lcdns_pkg, lcdns_out_if.
`default_nettype none
module lcdns_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lcdns_pkg::job_t   job,
  input  wire logic              job_valid,
  output logic                   job_pop,
  lcdns_out_if.source            out_if
);

  logic [4:0]          step_r;
  logic                out_valid_r;
  lcdns_pkg::result_t  out_r;
  lcdns_pkg::result_t  cur;
  logic                fire;
  logic [3:0]          byte_idx;
  logic [2:0]          glyph_row;
  logic [7:0]          cur_byte;

  assign byte_idx  = step_r[4:1];
  assign glyph_row = 3'(byte_idx - 4'd1);

  always_comb begin
    cur      = '0;
    cur_byte = job.byte_val;
    case (job.kind)
      lcdns_pkg::JOB_INIT: begin
        cur = lcdns_pkg::init_step(step_r);
      end
      lcdns_pkg::JOB_GLYPH: begin
        // address byte, eight row bytes, then back to display RAM
        if (byte_idx == 4'd0) begin
          cur_byte = job.byte_val;
          cur.rs   = 1'b0;
        end else if (byte_idx == 4'd9) begin
          cur_byte = lcdns_pkg::LCD_DDRAM_ADDR;
          cur.rs   = 1'b0;
        end else begin
          cur_byte = job.glyph[{glyph_row, 3'b000} +: 8];
          cur.rs   = 1'b1;
        end
        cur.strobe_res = 1'b1;
        cur.nibble     = step_r[0] ? cur_byte[3:0] : cur_byte[7:4];
        cur.wait_us    = lcdns_pkg::WAIT_BASE;
        cur.last       = (step_r == lcdns_pkg::GLYPH_LAST_STEP);
      end
      default: begin
        cur.strobe_res = 1'b1;
        cur.rs         = job.rs;
        cur.nibble     = step_r[0] ? cur_byte[3:0] : cur_byte[7:4];
        cur.wait_us    = (step_r[0] && job.long_wait) ? lcdns_pkg::WAIT_LONG
                                                      : lcdns_pkg::WAIT_BASE;
        cur.last       = step_r[0];
      end
    endcase
  end

  assign fire    = job_valid && (!out_valid_r || out_if.ready);
  assign job_pop = fire && cur.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        step_r      <= cur.last ? 5'd0 : step_r + 5'd1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= cur;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.strobe_res = out_r.strobe_res;
  assign out_if.rs         = out_r.rs;
  assign out_if.nibble     = out_r.nibble;
  assign out_if.wait_us    = out_r.wait_us;
  assign out_if.last       = out_r.last;

endmodule
`default_nettype wire

/* design/char_lcd_nibble_sequencer_top.sv */
// Top level of the character-LCD 4-bit nibble sequencer.
// Depends on lcdns_pkg, lcdns_in_if, lcdns_out_if, lcdns_front, lcdns_queue, lcdns_back.
//
// Each request expands into 4-bit bus strobes (register select, nibble on
// D7..D4, wait in microseconds after it), the last of a request flagged by
// last. A byte, clear, home, cursor or display on/off request yields 2
// strobes, init yields 15 and define glyph 20; an unknown request code
// yields none. The strobe sequencer in the back end delivers them on the
// result channel, one per cycle through an output register while the channel
// is ready. Requests are classified on acceptance and held in a
// QUEUE_DEPTH-entry job queue, so until it is full the request channel keeps
// accepting while strobes of earlier requests are still going out. Column
// and row counts are written over the APB port at byte addresses 0 and 4.
`default_nettype none
module char_lcd_nibble_sequencer_top #(
  parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  lcdns_in_if.sink                                 in_if,
  lcdns_out_if.source                              out_if,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [lcdns_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [lcdns_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [lcdns_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                     cfg_pready
);

  logic [5:0]       columns_r;
  logic [1:0]       rows_r;
  logic             cfg_write;
  lcdns_pkg::job_t  push_job;
  logic             push_valid;
  logic             push_ready;
  lcdns_pkg::job_t  pop_job;
  logic             pop_valid;
  logic             pop_ready;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= lcdns_pkg::COLUMNS_RESET;
      rows_r    <= lcdns_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[2])
        lcdns_pkg::REG_IDX_COLUMNS: columns_r <= cfg_pwdata[5:0];
        lcdns_pkg::REG_IDX_ROWS:    rows_r    <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      lcdns_pkg::REG_IDX_COLUMNS: cfg_prdata = {26'd0, columns_r};
      lcdns_pkg::REG_IDX_ROWS:    cfg_prdata = {30'd0, rows_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  lcdns_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .columns    (columns_r),
    .rows       (rows_r),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (pop_job),
    .job_valid (pop_valid),
    .job_pop   (pop_ready),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire

/* bench/lcdns_strobe_checker.sv */
`timescale 1ns / 1ps
// Strobe checker for the character-LCD nibble sequencer: watches both channels
// and the APB port, expands each accepted request into expected strobes and
// compares them in order. Depends on lcdns_pkg, lcdns_in_if and lcdns_out_if.
module lcdns_strobe_checker
  import lcdns_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lcdns_in_if                        req,
  lcdns_out_if                       strb,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic                  cfg_pready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                         fail_count,
  output int                         strobes_pending
);

  localparam logic [CFG_ADDR_W-1:0] ADDR_COLUMNS = {REG_IDX_COLUMNS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_ROWS    = {REG_IDX_ROWS, 2'b00};

  // Extra waits folded into the last strobe of a step
  localparam logic [15:0] EXTRA_NONE      = 16'd0;
  localparam logic [15:0] EXTRA_BYTE      = 16'd50;
  localparam logic [15:0] EXTRA_WAKE_NIB  = 16'd150;
  localparam logic [15:0] EXTRA_FIRST_NIB = 16'd5000;
  localparam logic [15:0] EXTRA_LONG      = 16'd2000;

  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [7:0] LCD_FUNC_SET = 8'h28;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;

  result_t    expected_strobes[$];
  logic [5:0] cols_cfg = COLUMNS_RESET;
  logic [1:0] rows_cfg = ROWS_RESET;
  logic [2:0] ctrl_bits = '0;

  initial begin
    fail_count = 0;
    strobes_pending = 0;
  end

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("%0t: strobe check: %s", $time, msg);
  endtask

  function automatic void add_nibble(input logic rs, input logic [3:0] nib,
                                     input logic [15:0] extra);
    result_t r;
    r = '{1'b1, rs, nib, WAIT_BASE + extra, 1'b0};
    expected_strobes.push_back(r);
  endfunction

  function automatic void add_byte(input logic rs, input logic [7:0] b,
                                   input logic [15:0] extra);
    add_nibble(rs, b[7:4], EXTRA_NONE);
    add_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void add_ctrl(input logic [15:0] extra);
    add_byte(1'b0, LCD_DISPLAY_CTRL | {5'b0, ctrl_bits}, extra);
  endfunction

  function automatic void expand_request(input logic [3:0] cmd, input logic [7:0] bv,
                                         input logic [7:0] row, input logic [7:0] col,
                                         input logic [7:0] loc, input logic [63:0] glyph);
    int         start_size;
    int         row_max;
    int         col_max;
    int         row_eff;
    int         col_eff;
    logic [6:0] ddram;
    result_t    power_up;
    start_size = expected_strobes.size();
    case (cmd)
      CMD_INIT: begin
        power_up = '{1'b0, 1'b0, 4'h0, WAIT_POWER_UP, 1'b0};
        expected_strobes.push_back(power_up);
        add_nibble(1'b0, NIB_WAKE, EXTRA_FIRST_NIB);
        add_nibble(1'b0, NIB_WAKE, EXTRA_WAKE_NIB);
        add_nibble(1'b0, NIB_WAKE, EXTRA_WAKE_NIB);
        add_nibble(1'b0, NIB_4BIT, EXTRA_WAKE_NIB);
        add_byte(1'b0, LCD_FUNC_SET, EXTRA_BYTE);
        ctrl_bits = '0;
        add_ctrl(EXTRA_BYTE);
        add_byte(1'b0, BYTE_CLEAR_DISPLAY, EXTRA_LONG);
        add_byte(1'b0, LCD_ENTRY, EXTRA_BYTE);
        ctrl_bits = CTRL_DISPLAY_ON;
        add_ctrl(EXTRA_BYTE);
      end
      CMD_CMD_BYTE:  add_byte(1'b0, bv, EXTRA_NONE);
      CMD_DATA_BYTE: add_byte(1'b1, bv, EXTRA_NONE);
      CMD_CLEAR:     add_byte(1'b0, BYTE_CLEAR_DISPLAY, EXTRA_LONG);
      CMD_HOME:      add_byte(1'b0, BYTE_RETURN_HOME, EXTRA_LONG);
      CMD_CURSOR: begin
        // zero counts act as one; only two row offsets exist
        row_max = (rows_cfg == 2'd0) ? 0 : int'(rows_cfg) - 1;
        if (row_max > 1) row_max = 1;
        col_max = (cols_cfg == 6'd0) ? 0 : int'(cols_cfg) - 1;
        row_eff = (int'(row) > row_max) ? row_max : int'(row);
        col_eff = (int'(col) > col_max) ? col_max : int'(col);
        ddram = 7'(col_eff) + ((row_eff != 0) ? LCD_ROW1_OFFSET : 7'h00);
        add_byte(1'b0, LCD_DDRAM_ADDR | {1'b0, ddram}, EXTRA_NONE);
      end
      CMD_DISP_ON: begin
        ctrl_bits = ctrl_bits | CTRL_DISPLAY_ON;
        add_ctrl(EXTRA_NONE);
      end
      CMD_DISP_OFF: begin
        ctrl_bits = ctrl_bits & CTRL_KEEP_MASK;
        add_ctrl(EXTRA_NONE);
      end
      CMD_GLYPH: begin
        add_byte(1'b0, LCD_CGRAM_ADDR | {2'b00, loc[2:0], 3'b000}, EXTRA_NONE);
        for (int i = 0; i < 8; i++) add_byte(1'b1, glyph[8*i +: 8], EXTRA_NONE);
        add_byte(1'b0, LCD_DDRAM_ADDR, EXTRA_NONE);
      end
      default: ;
    endcase
    if (expected_strobes.size() > start_size)
      expected_strobes[expected_strobes.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      cols_cfg = COLUMNS_RESET;
      rows_cfg = ROWS_RESET;
      ctrl_bits = '0;
      expected_strobes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_COLUMNS) cols_cfg = cfg_pwdata[5:0];
        else if (cfg_paddr == ADDR_ROWS) rows_cfg = cfg_pwdata[1:0];
      end
      if (req.valid && req.ready)
        expand_request(req.cmd, req.byte_value, req.row, req.col, req.location, req.glyph);
      if (strb.valid && strb.ready) begin
        if (expected_strobes.size() == 0) begin
          flag_mismatch($sformatf("strobe with nothing expected (nib %h wait %0d)",
                                  strb.nibble, strb.wait_us));
        end else begin
          want = expected_strobes.pop_front();
          if (strb.strobe_res !== want.strobe_res)
            flag_mismatch($sformatf("strobe_res %b, want %b", strb.strobe_res,
                                    want.strobe_res));
          if (strb.rs !== want.rs)
            flag_mismatch($sformatf("rs %b, want %b", strb.rs, want.rs));
          if (strb.nibble !== want.nibble)
            flag_mismatch($sformatf("nibble %h, want %h", strb.nibble, want.nibble));
          if (strb.wait_us !== want.wait_us)
            flag_mismatch($sformatf("wait_us %0d, want %0d", strb.wait_us, want.wait_us));
          if (strb.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", strb.last, want.last));
        end
      end
    end
    strobes_pending = expected_strobes.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the nibble sequencer bench: clock, reset, request and APB stimulus,
// result-side stalls and the verdict. Depends on lcdns_pkg, the channel
// interfaces, char_lcd_nibble_sequencer_top and lcdns_strobe_checker.
module tb_top;
  import lcdns_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASE_ITEMS    = 63;
  localparam int NUM_PHASES     = 6;
  localparam int IDLE_PCT       = 16;

  localparam logic [CFG_ADDR_W-1:0] ADDR_COLUMNS = {REG_IDX_COLUMNS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_ROWS    = {REG_IDX_ROWS, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int strobes_pending;
  int cycle_count = 0;
  int idle_in = IDLE_PCT;
  int idle_out = IDLE_PCT;
  bit holdoff_go = 1'b0;

  lcdns_in_if  req_ch ();
  lcdns_out_if strobe_ch ();

  char_lcd_nibble_sequencer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (req_ch),
    .out_if      (strobe_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lcdns_strobe_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req_ch),
    .strb            (strobe_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .strobes_pending (strobes_pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    strobe_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_go) begin
        holdoff_go = 1'b0;
        strobe_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
      end else begin
        strobe_ch.ready <= ($urandom_range(99) >= idle_out);
      end
    end
  end

  task automatic send_req(input logic [3:0] cmd, input logic [7:0] bv, input logic [7:0] row,
                          input logic [7:0] col, input logic [7:0] loc,
                          input logic [63:0] gl);
    @(negedge clk);
    while ($urandom_range(99) < idle_in) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.byte_value <= bv;
    req_ch.row        <= row;
    req_ch.col        <= col;
    req_ch.location   <= loc;
    req_ch.glyph      <= gl;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid, wait out expected strobes, then let ignored requests drain
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (strobes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_random_batch(input int count);
    int         done;
    int         pick;
    logic [3:0] cmd;
    logic [7:0] row;
    logic [7:0] col;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 22)      cmd = CMD_DATA_BYTE;
      else if (pick < 38) cmd = CMD_CMD_BYTE;
      else if (pick < 54) cmd = CMD_CURSOR;
      else if (pick < 62) cmd = CMD_DISP_ON;
      else if (pick < 70) cmd = CMD_DISP_OFF;
      else if (pick < 77) cmd = CMD_CLEAR;
      else if (pick < 83) cmd = CMD_HOME;
      else if (pick < 92) cmd = CMD_GLYPH;
      else if (pick < 95) cmd = CMD_INIT;
      else                cmd = 4'($urandom_range(15, 9));
      // keep cursor values near the clamp points half of the time
      row = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      col = $urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom_range(255));
      send_req(cmd, 8'($urandom_range(255)), row, col, 8'($urandom_range(255)),
               {$urandom, $urandom});
      if (cmd <= CMD_GLYPH) done++;
    end
  endtask

  initial begin : stimulus
    int ncols;
    int nrows;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = '0;
    req_ch.byte_value = '0;
    req_ch.row        = '0;
    req_ch.col        = '0;
    req_ch.location   = '0;
    req_ch.glyph      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset register values
    send_req(CMD_DISP_ON, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_DISP_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_INIT, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_CMD_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_DATA_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_DATA_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_DATA_BYTE, 8'hA5, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_HOME, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_CURSOR, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_CURSOR, 8'h00, 8'h01, 8'h0F, 8'h00, 64'h0);
    send_req(CMD_CURSOR, 8'h00, 8'h00, 8'h10, 8'h00, 64'h0);
    send_req(CMD_CURSOR, 8'h00, 8'hFF, 8'hFF, 8'h00, 64'h0);
    send_req(CMD_DISP_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_DISP_ON, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_GLYPH, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(CMD_GLYPH, 8'h00, 8'h00, 8'h00, 8'hFF, {64{1'b1}});
    send_req(CMD_GLYPH, 8'h00, 8'h00, 8'h00, 8'h5A, 64'h0123_4567_89AB_CDEF);
    send_req(4'd9, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_req(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, {64{1'b1}});
    send_req(CMD_DATA_BYTE, 8'h5A, 8'h00, 8'h00, 8'h00, 64'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin ncols = 1;  nrows = 1; end
        1: begin ncols = 40; nrows = 2; end
        2: begin ncols = 0;  nrows = 0; end
        3: begin ncols = 63; nrows = 3; end
        4: begin ncols = $urandom_range(63); nrows = $urandom_range(3); end
        default: begin ncols = 40; nrows = 3; end
      endcase
      write_reg(ADDR_COLUMNS, ncols);
      write_reg(ADDR_ROWS, nrows);
      // one phase runs with no idling at all on either side
      idle_in  = (p == 1) ? 0 : IDLE_PCT;
      idle_out = (p == 1) ? 0 : IDLE_PCT;
      if (p == 3) holdoff_go = 1'b1;
      send_random_batch(PHASE_ITEMS);
    end

    settle();
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
